[rtl/nearest_interval_search_unit_assert.svh]
// Assertion macros for the nearest interval search unit.
`ifndef NEAREST_INTERVAL_SEARCH_UNIT_ASSERT_SVH
`define NEAREST_INTERVAL_SEARCH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define NIS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define NIS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define NIS_ASSERT(lbl, prop, msg)
`define NIS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[rtl/nis_pkg.sv]
// Shared types and constants for the nearest interval search unit.
package nis_pkg;

    localparam int COORD_W     = 31;
    localparam int HIT_IDX_W   = 8;
    localparam int S_TDATA_W   = 128;
    localparam int M_TDATA_W   = 48;

    // Item kinds carried on s_tuser
    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2
    } action_t;

    // Query word walking down the cell row, with its best match so far
    typedef struct packed {
        logic                 valid;
        logic                 upstream;
        logic [COORD_W-1:0]   pos;
        logic [COORD_W-1:0]   lim;
        logic                 found;
        logic                 contained;
        logic [HIT_IDX_W-1:0] idx;
        logic [COORD_W-1:0]   gap;
    } token_t;

endpackage

[rtl/nis_cell.sv]
// One table entry of the search row: holds an interval and scores the passing query.
module nis_cell
    import nis_pkg::*;
#(
    parameter int CELL_INDEX = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               live,
    input  logic               wr_en,
    input  logic [COORD_W-1:0] wr_start,
    input  logic [COORD_W-1:0] wr_end,
    input  token_t             tok_in,
    output token_t             tok_out
);

    logic [COORD_W-1:0] start_reg;
    logic [COORD_W-1:0] end_reg;
    token_t             tok_reg;
    token_t             tok_next;
    logic               contain;
    logic               reach;
    logic [COORD_W-1:0] g;

    // Hold the interval written by an append
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_reg <= wr_start;
            end_reg   <= wr_end;
        end
    end

    // Score this entry against the incoming query word
    always_comb
    begin
        tok_next = tok_in;
        contain  = (start_reg <= tok_in.pos) && (end_reg >= tok_in.pos);
        if (tok_in.upstream)
        begin
            reach = (end_reg <= tok_in.pos);
            g     = tok_in.pos - end_reg;
        end
        else
        begin
            reach = (start_reg >= tok_in.pos);
            g     = start_reg - tok_in.pos;
        end
        if (tok_in.valid && live && !tok_in.contained)
        begin
            priority if (contain)
            begin
                tok_next.found     = 1'b1;
                tok_next.contained = 1'b1;
                tok_next.idx       = HIT_IDX_W'(CELL_INDEX);
                tok_next.gap       = '0;
            end
            else if (reach && (g <= tok_in.lim) && (!tok_in.found || (g < tok_in.gap)))
            begin
                tok_next.found = 1'b1;
                tok_next.idx   = HIT_IDX_W'(CELL_INDEX);
                tok_next.gap   = g;
            end
            else
            begin
                // Pass the best match so far unchanged
                tok_next = tok_in;
            end
        end
    end

    // Hand the word to the next cell unless the row is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[rtl/nearest_interval_search_unit.sv]
// Clear and append words give no result.
// A query walks the row of TABLE_ENTRIES cells, one cell a cycle, and its result is
// registered at the row's end before it shows on m_tvalid; the row length sets the delay.
// One query is in the row at a time: no word is taken until the query's result is loaded
// into the output register, and that waits while m_tready holds the previous result back.
// Reset empties the table and drops any query in flight; entries stay undefined until appended.
module nearest_interval_search_unit
    import nis_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // interval_start, interval_end, query_position, distance_limit, look_upstream
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // hit, inside_res, hit_index, gap
    output logic [M_TDATA_W-1:0] m_tdata
);

`include "nearest_interval_search_unit_assert.svh"

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_hit_reg;
    logic                 out_inside_reg;
    logic [HIT_IDX_W-1:0] out_idx_reg;
    logic [COORD_W-1:0]   out_gap_reg;

    action_t              act;
    logic                 in_fire;
    logic                 query_fire;
    logic                 append_fire;
    logic                 out_load;
    logic                 advance;
    logic [COORD_W-1:0]   in_start;
    logic [COORD_W-1:0]   in_end;
    token_t               tok [TABLE_ENTRIES+1];
    token_t               tail;

    // Unpack the input word
    assign act      = action_t'(s_tuser);
    assign in_start = s_tdata[30:0];
    assign in_end   = s_tdata[61:31];

    assign s_tready    = !busy_reg;
    assign in_fire     = s_tvalid && s_tready;
    assign query_fire  = in_fire && (act == ACT_QUERY);
    assign append_fire = in_fire && (act == ACT_APPEND)
                         && (count_reg < CNT_W'(TABLE_ENTRIES));

    // Launch a fresh query word into the first cell
    always_comb
    begin
        tok[0]          = '0;
        tok[0].valid    = query_fire;
        tok[0].pos      = s_tdata[92:62];
        tok[0].lim      = s_tdata[123:93];
        tok[0].upstream = s_tdata[124];
    end

    assign tail     = tok[TABLE_ENTRIES];
    assign out_load = tail.valid && (!out_valid_reg || m_tready);
    assign advance  = !tail.valid || out_load;

    // Row of table cells
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        nis_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .live     (count_reg > CNT_W'(i)),
            .wr_en    (append_fire && (count_reg == CNT_W'(i))),
            .wr_start (in_start),
            .wr_end   (in_end),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );
    end

    // Next table fill, busy flag and output valid
    always_comb
    begin
        count_next = count_reg;
        if (in_fire)
        begin
            unique case (act)
                ACT_CLEAR:  count_next = '0;
                ACT_APPEND:
                begin
                    if (append_fire)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                default:    count_next = count_reg;
            endcase
        end

        busy_next = busy_reg;
        if (query_fire)
        begin
            busy_next = 1'b1;
        end
        else if (out_load)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the finished query word
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hit_reg    <= tail.found;
            out_inside_reg <= tail.contained;
            out_idx_reg    <= tail.idx;
            out_gap_reg    <= tail.gap;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_gap_reg, out_idx_reg, out_inside_reg, out_hit_reg};

    `NIS_ASSERT(a_query_sets_busy, query_fire |=> busy_reg, "query accepted but unit not busy")
    `NIS_ASSERT_ALWAYS(a_idle_row_empty, !busy_reg |-> !tail.valid, "query word in idle row")
    `NIS_ASSERT(a_stall_holds_tail, (tail.valid && !out_load) |=> tail.valid, "stalled query lost")
    `NIS_ASSERT(a_miss_zero, (m_tvalid && !m_tdata[0]) |-> (m_tdata[40:1] == '0), "miss not zero")
    `NIS_ASSERT(a_inside_gap, (m_tvalid && m_tdata[1]) |-> (m_tdata[0] && (m_tdata[40:10] == '0)), "inside hit with gap")

endmodule
